// ===== hdl/wqc_pkg.sv =====
// Types, constants and codes shared by the windowed quota counter.
package wqc_pkg;

    localparam int TIME_W        = 62;
    localparam int CNT_W         = 48;
    localparam int QT_W          = 2;
    localparam int NUM_TYPES_DEF = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 62;
    localparam int STEP_W        = $clog2(TIME_W);

    localparam logic [TIME_W-1:0] LEN_RST  = TIME_W'(1000000);
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef enum logic [1:0] {
        FUNC_ADD,
        FUNC_CHECK_ONE,
        FUNC_CHECK_ALL,
        FUNC_READ
    } t_func;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LENGTH,
        CFG_PHASE,
        CFG_LIMIT0,
        CFG_LIMIT1,
        CFG_LIMIT2,
        CFG_LIMIT3
    } t_cfg_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_START,
        S_PROBE,
        S_DIV,
        S_ROLL,
        S_FIN
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [QT_W-1:0]    res_type;
        logic [CNT_W-1:0]   amount;
        logic               check_flag;
        logic [TIME_W-1:0]  stamp;
    } t_req;

    typedef struct packed {
        logic               exceeded;
        logic [QT_W-1:0]    exceeded_type;
        logic [CNT_W-1:0]   used_value;
        logic [CNT_W-1:0]   limit_value;
        logic [TIME_W-1:0]  interval_end;
        logic               counters_reset;
    } t_rsp;

endpackage

// ===== hdl/windowed_quota_counter_core.sv =====
// Fixed-window quota counter: usage accounting with iterative window rollover.
//
//  channel  direction  handshake                     payload
//  req      in         i_req_valid / o_req_stall     i_req (t_req)
//  rsp      out        o_rsp_valid / i_rsp_stall     o_rsp (t_rsp)
//  cfg      in         i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
//  An item without rollover passes S_START, S_PROBE and S_FIN, then is back in
//  S_IDLE; a bad type skips S_PROBE, and check-all probes each type it scans.
//  Each window rollover runs a 62-step restoring remainder unit in S_DIV, one bit
//  per cycle, then forms the new window end in S_ROLL; on check-all S_PROBE then
//  probes the cleared type again. The first item also passes the alignment state
//  S_ALIGN and may roll twice (alignment and quota rollover).
//  i_rst_n is synchronous, active low; it clears state, counters, limits and phase.
//  A result waits in the output register under i_rsp_stall; the next request is
//  accepted meanwhile and finishes once that register is free.
module windowed_quota_counter_core #(
    parameter int NUM_TYPES = wqc_pkg::NUM_TYPES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_stall,
    input  wqc_pkg::t_req                     i_req,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_stall,
    output wqc_pkg::t_rsp                     o_rsp,
    input  logic                              i_cfg_we,
    input  logic [wqc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [wqc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import wqc_pkg::*;

    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [TW-1:0] LAST_IDX = TW'(NUM_TYPES - 1);

    t_state               r_state, n_state;
    logic [TIME_W-1:0]    r_len, r_phase;
    logic [CNT_W-1:0]     r_lim [NUM_TYPES];
    logic [CNT_W-1:0]     r_cnt [NUM_TYPES];
    logic [CNT_W-1:0]     n_cnt [NUM_TYPES];
    logic [TIME_W-1:0]    r_wend, n_wend;
    logic                 r_aligned, n_aligned;
    t_req                 r_req, n_req;
    logic [TW-1:0]        r_idx, n_idx;
    logic                 r_exc, n_exc;
    logic [QT_W-1:0]      r_rt, n_rt;
    logic                 r_rst_flag, n_rst_flag;
    logic                 r_clr, n_clr;
    logic [TIME_W-1:0]    r_rem, n_rem;
    logic [TIME_W-1:0]    r_dvd, n_dvd;
    logic [STEP_W-1:0]    r_step, n_step;
    t_rsp                 r_rsp, n_rsp;
    logic                 r_rsp_valid, n_rsp_valid;

    logic                 is_all;
    logic                 type_ok;
    logic [TW-1:0]        qt_idx;
    logic [TW-1:0]        sel_idx;
    logic [CNT_W-1:0]     sel_cnt;
    logic [CNT_W-1:0]     sel_lim;
    logic                 over;
    logic                 due;
    logic                 probe_roll;
    logic [TIME_W-1:0]    dsr;
    logic [TIME_W:0]      rem_sh;
    logic                 rem_ge;
    logic [TIME_W:0]      rem_nx;
    logic [TIME_W:0]      end_sum;
    logic [TIME_W-1:0]    end_new;
    logic [CNT_W:0]       add_sum;
    logic [CNT_W-1:0]     add_sat;
    logic                 out_free;

    // shared datapath
    always_comb begin
        is_all  = (r_req.func == FUNC_CHECK_ALL);
        type_ok = ({1'b0, r_req.res_type} < (QT_W + 1)'(NUM_TYPES));
        qt_idx  = r_req.res_type[TW-1:0];
        if (is_all) begin
            sel_idx = (r_state == S_FIN) ? r_rt[TW-1:0] : r_idx;
        end else begin
            sel_idx = qt_idx;
        end
        sel_cnt = r_cnt[sel_idx];
        sel_lim = r_lim[sel_idx];
        over    = (sel_lim != '0) && (sel_cnt > sel_lim);
        due     = (r_req.stamp >= r_wend);
        if (r_req.func == FUNC_READ) begin
            probe_roll = due;
        end else begin
            probe_roll = over && due;
        end
        dsr     = (r_len == '0) ? TIME_W'(1) : r_len;
        rem_sh  = {r_rem, r_dvd[TIME_W-1]};
        rem_ge  = (rem_sh >= {1'b0, dsr});
        rem_nx  = rem_ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
        end_sum = {1'b0, r_req.stamp} - {1'b0, r_rem} + {1'b0, dsr};
        end_new = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
        add_sum = {1'b0, sel_cnt} + {1'b0, r_req.amount};
        add_sat = add_sum[CNT_W] ? CNT_MAX : add_sum[CNT_W-1:0];
        out_free = !r_rsp_valid || !i_rsp_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = r_aligned ? S_START : S_ALIGN;
                end
            end
            S_ALIGN: begin
                n_state = due ? S_DIV : S_START;
            end
            S_START: begin
                n_state = (!is_all && !type_ok) ? S_FIN : S_PROBE;
            end
            S_PROBE: begin
                if (probe_roll) begin
                    n_state = S_DIV;
                end else if (is_all && !over && (r_idx != LAST_IDX)) begin
                    n_state = S_PROBE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                n_state = (r_step == '0) ? S_ROLL : S_DIV;
            end
            S_ROLL: begin
                if (!r_clr) begin
                    n_state = S_START;
                end else begin
                    n_state = is_all ? S_PROBE : S_FIN;
                end
            end
            S_FIN: begin
                n_state = out_free ? S_IDLE : S_FIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_cnt       = r_cnt;
        n_wend      = r_wend;
        n_aligned   = r_aligned;
        n_req       = r_req;
        n_idx       = r_idx;
        n_exc       = r_exc;
        n_rt        = r_rt;
        n_rst_flag  = r_rst_flag;
        n_clr       = r_clr;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_step      = r_step;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req      = i_req;
                    n_idx      = '0;
                    n_exc      = 1'b0;
                    n_rt       = '0;
                    n_rst_flag = 1'b0;
                    if (!r_aligned) begin
                        n_wend    = r_phase;
                        n_aligned = 1'b1;
                    end
                end
            end
            S_ALIGN: begin
                if (due) begin
                    n_rem  = '0;
                    n_dvd  = r_req.stamp - r_wend;
                    n_step = STEP_W'(TIME_W - 1);
                    n_clr  = 1'b0;
                end
            end
            S_START: begin
                if ((r_req.func == FUNC_ADD) && type_ok) begin
                    n_cnt[qt_idx] = add_sat;
                end
            end
            S_PROBE: begin
                if (probe_roll) begin
                    n_rem  = '0;
                    n_dvd  = r_req.stamp - r_wend;
                    n_step = STEP_W'(TIME_W - 1);
                    n_clr  = 1'b1;
                end else if (is_all) begin
                    if (over) begin
                        n_exc = 1'b1;
                        n_rt  = QT_W'(r_idx);
                    end else begin
                        n_idx = r_idx + TW'(1);
                    end
                end
            end
            S_DIV: begin
                n_rem  = rem_nx[TIME_W-1:0];
                n_dvd  = {r_dvd[TIME_W-2:0], 1'b0};
                n_step = r_step - STEP_W'(1);
            end
            S_ROLL: begin
                n_wend = end_new;
                if (r_clr) begin
                    n_rst_flag = 1'b1;
                    for (int k = 0; k < NUM_TYPES; k++) begin
                        n_cnt[k] = '0;
                    end
                    if (r_req.func == FUNC_ADD) begin
                        n_cnt[qt_idx] = r_req.amount;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_rsp_valid          = 1'b1;
                    n_rsp.interval_end   = r_wend;
                    n_rsp.counters_reset = r_rst_flag;
                    if (is_all) begin
                        n_rsp.exceeded      = r_exc;
                        n_rsp.exceeded_type = r_rt;
                        n_rsp.used_value    = sel_cnt;
                        n_rsp.limit_value   = sel_lim;
                    end else begin
                        n_rsp.exceeded      = type_ok && over &&
                            ((r_req.func != FUNC_ADD) || r_req.check_flag);
                        n_rsp.exceeded_type = r_req.res_type;
                        n_rsp.used_value    = type_ok ? sel_cnt : '0;
                        n_rsp.limit_value   = type_ok ? sel_lim : '0;
                    end
                end
            end
            default: begin
                n_rsp_valid = r_rsp_valid && i_rsp_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_RST;
            r_phase     <= '0;
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_lim[k] <= '0;
                r_cnt[k] <= '0;
            end
            r_wend      <= '0;
            r_aligned   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wend      <= n_wend;
            r_aligned   <= n_aligned;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_LENGTH) begin
                    r_len <= i_cfg_wdata[TIME_W-1:0];
                end
                if (i_cfg_addr == CFG_PHASE) begin
                    r_phase <= i_cfg_wdata[TIME_W-1:0];
                end
                for (int k = 0; k < NUM_TYPES; k++) begin
                    if (i_cfg_addr == (CFG_LIMIT0 + CFG_ADDR_W'(k))) begin
                        r_lim[k] <= i_cfg_wdata[CNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_exc      <= n_exc;
        r_rt       <= n_rt;
        r_rst_flag <= n_rst_flag;
        r_clr      <= n_clr;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_step     <= n_step;
        r_rsp      <= n_rsp;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_aligned_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aligned |=> r_aligned)
        else $error("window alignment lost");

    a_roll_past_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROLL) |=> ((r_wend > r_req.stamp) || (r_wend == TIME_MAX)))
        else $error("rolled window end not past current time");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < dsr))
        else $error("remainder not below window length");

    a_exceeded_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.exceeded) |-> (r_rsp.used_value > r_rsp.limit_value))
        else $error("exceeded reported with usage within limit");

endmodule

// ===== bench/windowed_quota_counter_core_tb.sv =====
// Self-checking testbench for the windowed quota counter: directed plan, random phases.
`timescale 1ns / 100ps

module windowed_quota_counter_core_tb;
    import wqc_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 210;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS   = 20_000_000;

    localparam logic [63:0] CNT_MAX64  = {16'd0, CNT_MAX};
    localparam logic [63:0] TIME_MAX64 = {2'd0, TIME_MAX};

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_RANDOM
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_addr   addr;
        logic [63:0] value;
        t_req        req;
        bit          typed;
        t_rsp        typed_rsp;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_stall;
    t_req                  i_req       = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_stall = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // window and counter state as the block should hold it
    logic [63:0] win_len       = 64'd1000000;
    logic [63:0] win_phase     = 64'd0;
    logic [63:0] limit_reg [4] = '{default: 64'd0};
    logic [63:0] usage_cnt [4] = '{default: 64'd0};
    logic [63:0] win_end       = 64'd0;
    bit          win_aligned   = 1'b0;

    t_rsp rsp_expected_q [$];
    t_row plan [$];
    int   mismatch_cnt  = 0;
    int   req_idle_pct  = 0;
    int   rsp_stall_pct = 0;
    int   hold_left     = 0;
    bit   hold_request  = 1'b0;

    windowed_quota_counter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit roll_window_to(input logic [63:0] t);
        logic [63:0] d, q, e;
        if (t < win_end) begin
            return 1'b0;
        end
        d = (win_len == 0) ? 64'd1 : win_len;
        q = (t - win_end) / d;
        e = win_end + q * d + d;
        win_end = (e > TIME_MAX64) ? TIME_MAX64 : e;
        return 1'b1;
    endfunction

    function automatic t_rsp quota_predict(input t_req r);
        t_rsp        rsp;
        logic [63:0] t, u, lim;
        logic [1:0]  rt;
        bit          rolled, exc, found;
        t = {2'd0, r.stamp};
        rt = r.res_type;
        rolled = 1'b0;
        exc = 1'b0;
        found = 1'b0;
        if (!win_aligned) begin
            win_end = win_phase;
            void'(roll_window_to(t));
            win_aligned = 1'b1;
        end
        case (r.func)
            FUNC_ADD: begin
                lim = limit_reg[rt];
                u = usage_cnt[rt] + {16'd0, r.amount};
                if (u > CNT_MAX64) u = CNT_MAX64;
                usage_cnt[rt] = u;
                if (lim != 0 && u > lim) begin
                    if (roll_window_to(t)) begin
                        foreach (usage_cnt[k]) usage_cnt[k] = 64'd0;
                        rolled = 1'b1;
                        u = {16'd0, r.amount};
                        usage_cnt[rt] = u;
                    end
                    exc = r.check_flag && u > lim;
                end
            end
            FUNC_CHECK_ONE: begin
                lim = limit_reg[rt];
                if (lim != 0 && usage_cnt[rt] > lim) begin
                    if (roll_window_to(t)) begin
                        foreach (usage_cnt[k]) usage_cnt[k] = 64'd0;
                        rolled = 1'b1;
                    end else begin
                        exc = 1'b1;
                    end
                end
            end
            FUNC_CHECK_ALL: begin
                rt = 2'd0;
                for (int i = 0; i < 4 && !found; i++) begin
                    lim = limit_reg[i];
                    if (lim != 0 && usage_cnt[i] > lim) begin
                        if (roll_window_to(t)) begin
                            foreach (usage_cnt[k]) usage_cnt[k] = 64'd0;
                            rolled = 1'b1;
                        end else begin
                            exc = 1'b1;
                            rt = 2'(i);
                            found = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (roll_window_to(t)) begin
                    foreach (usage_cnt[k]) usage_cnt[k] = 64'd0;
                    rolled = 1'b1;
                end
                exc = limit_reg[rt] != 0 && usage_cnt[rt] > limit_reg[rt];
            end
        endcase
        rsp.exceeded       = exc;
        rsp.exceeded_type  = rt;
        rsp.used_value     = usage_cnt[rt][CNT_W-1:0];
        rsp.limit_value    = limit_reg[rt][CNT_W-1:0];
        rsp.interval_end   = win_end[TIME_W-1:0];
        rsp.counters_reset = rolled;
        return rsp;
    endfunction

    function automatic t_rsp rsp_of(input bit exc, input logic [1:0] rt,
                                    input logic [63:0] used, input logic [63:0] lim,
                                    input logic [63:0] iend, input bit rolled);
        t_rsp rsp;
        rsp.exceeded       = exc;
        rsp.exceeded_type  = rt;
        rsp.used_value     = used[CNT_W-1:0];
        rsp.limit_value    = lim[CNT_W-1:0];
        rsp.interval_end   = iend[TIME_W-1:0];
        rsp.counters_reset = rolled;
        return rsp;
    endfunction

    task automatic add_cfg(input t_cfg_addr a, input logic [63:0] v);
        t_row r;
        r.kind = ROW_CFG;
        r.addr = a;
        r.value = v;
        r.req = '0;
        r.typed = 1'b0;
        r.typed_rsp = '0;
        plan = {plan, r};
    endtask

    task automatic add_req(input t_func f, input logic [1:0] qt, input logic [63:0] amt,
                           input bit chk, input logic [63:0] t, input bit typed,
                           input t_rsp rsp);
        t_row r;
        r.kind = (f == FUNC_ADD && qt == 2'd0 && t == TIME_MAX64 + 1) ? ROW_RANDOM : ROW_REQ;
        r.addr = CFG_LENGTH;
        r.value = 64'd0;
        r.req.func = f;
        r.req.res_type = qt;
        r.req.amount = amt[CNT_W-1:0];
        r.req.check_flag = chk;
        r.req.stamp = t[TIME_W-1:0];
        r.typed = typed;
        r.typed_rsp = rsp;
        plan = {plan, r};
    endtask

    function automatic logic [63:0] pick_limit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return 64'd0;
        if (sel < 75) return 64'($urandom_range(1, 64));
        if (sel < 90) return 64'($urandom_range(65, 5000));
        if (sel < 95) return CNT_MAX64;
        return {$urandom, $urandom} & CNT_MAX64;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        logic [63:0] d, t, amt;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) r.func = FUNC_ADD;
        else if (sel < 70) r.func = FUNC_CHECK_ONE;
        else if (sel < 85) r.func = FUNC_CHECK_ALL;
        else r.func = FUNC_READ;
        r.res_type = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 70) amt = 64'($urandom_range(0, 40));
        else if (sel < 85) amt = 64'($urandom_range(0, 5000));
        else if (sel < 95) amt = {$urandom, $urandom} & CNT_MAX64;
        else amt = CNT_MAX64;
        r.amount = amt[CNT_W-1:0];
        r.check_flag = 1'($urandom_range(0, 1));
        d = (win_len == 0) ? 64'd1 : win_len;
        if ($urandom_range(0, 99) < 3) begin
            t = {$urandom, $urandom} & TIME_MAX64;
        end else begin
            // land within a window or two of the current window end
            t = win_end + 64'($urandom_range(0, 3 * d[31:0]));
            t = (t < d) ? 64'd0 : t - d;
            if (t > TIME_MAX64) t = win_end;
        end
        r.stamp = t[TIME_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    task automatic send_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        while ($urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_req_stall);
        predicted = quota_predict(r);
        rsp_expected_q = {rsp_expected_q, (typed ? typed_rsp : predicted)};
    endtask

    task automatic wait_idle();
        i_req_valid <= 1'b0;
        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr a, input logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= v[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (a)
            CFG_LENGTH: win_len = v & TIME_MAX64;
            CFG_PHASE:  win_phase = v & TIME_MAX64;
            default:    limit_reg[2'(a - CFG_LIMIT0)] = v & CNT_MAX64;
        endcase
    endtask

    task automatic pick_window_setup();
        logic [63:0] len;
        case ($urandom_range(0, 3))
            0:       len = 64'($urandom_range(1, 16));
            1:       len = 64'($urandom_range(17, 1000));
            2:       len = 64'd0;
            default: len = 64'($urandom_range(1001, 1 << 20));
        endcase
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_PHASE, {$urandom, $urandom} & TIME_MAX64);
        write_reg(CFG_LIMIT0, pick_limit());
        write_reg(CFG_LIMIT1, pick_limit());
        write_reg(CFG_LIMIT2, pick_limit());
        write_reg(CFG_LIMIT3, pick_limit());
    endtask

    task automatic run_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0: begin
                    req_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1: begin
                    req_idle_pct = 88;
                    rsp_stall_pct = 0;
                end
                2: begin
                    req_idle_pct = 0;
                    rsp_stall_pct = 88;
                end
                default: begin
                    req_idle_pct = 15;
                    rsp_stall_pct = 15;
                end
            endcase
            pick_window_setup();
            // hold the response side while requests keep coming
            if (p == 4) hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
        end
        wait_idle();
        req_idle_pct = 0;
        rsp_stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (rsp_expected_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                mismatch_cnt++;
            end else begin
                want = rsp_expected_q.pop_front();
                check_field("exceeded", 64'(want.exceeded), 64'(o_rsp.exceeded));
                check_field("exceeded_type", 64'(want.exceeded_type),
                            64'(o_rsp.exceeded_type));
                check_field("used_value", 64'(want.used_value), 64'(o_rsp.used_value));
                check_field("limit_value", 64'(want.limit_value), 64'(o_rsp.limit_value));
                check_field("interval_end", 64'(want.interval_end),
                            64'(o_rsp.interval_end));
                check_field("counters_reset", 64'(want.counters_reset),
                            64'(o_rsp.counters_reset));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
        end
    end

    initial begin
        // first request aligns to a phase beyond the interval length
        add_cfg(CFG_PHASE, 64'd2500000);
        add_req(FUNC_READ, 2'd0, 64'd0, 1'b0, 64'd100, 1'b1,
                rsp_of(1'b0, 2'd0, 64'd0, 64'd0, 64'd2500000, 1'b0));
        add_req(FUNC_READ, 2'd1, 64'd0, 1'b0, 64'd2500000, 1'b1,
                rsp_of(1'b0, 2'd1, 64'd0, 64'd0, 64'd3500000, 1'b1));
        add_req(FUNC_READ, 2'd2, 64'd0, 1'b0, 64'd5000000, 1'b1,
                rsp_of(1'b0, 2'd2, 64'd0, 64'd0, 64'd5500000, 1'b1));
        add_cfg(CFG_LENGTH, 64'd1000);
        add_cfg(CFG_LIMIT0, 64'd10);
        add_cfg(CFG_LIMIT1, CNT_MAX64);
        add_cfg(CFG_LIMIT2, 64'd0);
        add_cfg(CFG_LIMIT3, 64'd5);
        add_req(FUNC_ADD, 2'd0, 64'd7, 1'b1, 64'd5000100, 1'b0, '0);
        add_req(FUNC_ADD, 2'd0, 64'd4, 1'b1, 64'd5000200, 1'b0, '0);
        add_req(FUNC_ADD, 2'd0, 64'd3, 1'b0, 64'd5000200, 1'b0, '0);
        add_req(FUNC_CHECK_ONE, 2'd0, 64'd0, 1'b0, 64'd5000300, 1'b0, '0);
        add_req(FUNC_ADD, 2'd1, CNT_MAX64, 1'b1, 64'd5000300, 1'b0, '0);
        add_req(FUNC_ADD, 2'd1, CNT_MAX64, 1'b1, 64'd5000300, 1'b0, '0);
        add_req(FUNC_ADD, 2'd2, 64'd1000, 1'b1, 64'd5000350, 1'b0, '0);
        add_req(FUNC_ADD, 2'd3, 64'd6, 1'b1, 64'd5000350, 1'b0, '0);
        add_req(FUNC_CHECK_ALL, 2'd3, 64'd0, 1'b0, 64'd5000400, 1'b0, '0);
        add_req(FUNC_CHECK_ALL, 2'd1, 64'd0, 1'b1, 64'd5600000, 1'b0, '0);
        add_req(FUNC_ADD, 2'd3, 64'd9, 1'b1, 64'd5600500, 1'b0, '0);
        add_req(FUNC_ADD, 2'd3, 64'd2, 1'b1, 64'd5601000, 1'b0, '0);
        add_req(FUNC_CHECK_ONE, 2'd3, 64'd0, 1'b0, 64'd5601500, 1'b0, '0);
        add_req(FUNC_ADD, 2'd3, 64'd7, 1'b1, 64'd5603000, 1'b0, '0);
        add_req(FUNC_CHECK_ONE, 2'd3, 64'd0, 1'b0, 64'd5604000, 1'b0, '0);
        add_req(FUNC_READ, 2'd3, 64'd0, 1'b0, 64'd5605000, 1'b0, '0);
        add_cfg(CFG_LENGTH, 64'd0);
        add_req(FUNC_ADD, 2'd0, 64'd20, 1'b1, 64'd5605010, 1'b0, '0);
        add_req(FUNC_READ, 2'd0, 64'd0, 1'b0, 64'd5605011, 1'b0, '0);
        add_req(FUNC_CHECK_ONE, 2'd1, 64'd0, 1'b0, 64'd5605020, 1'b0, '0);
        // random phases run here; the saturating window end must come last
        add_req(FUNC_ADD, 2'd0, 64'd0, 1'b0, TIME_MAX64 + 1, 1'b0, '0);
        add_cfg(CFG_LENGTH, TIME_MAX64);
        add_cfg(CFG_PHASE, TIME_MAX64);
        add_cfg(CFG_LIMIT0, 64'd1);
        add_req(FUNC_ADD, 2'd0, 64'd5, 1'b1, TIME_MAX64, 1'b1,
                rsp_of(1'b1, 2'd0, 64'd5, 64'd1, TIME_MAX64, 1'b1));
        add_req(FUNC_READ, 2'd0, 64'd0, 1'b0, TIME_MAX64, 1'b1,
                rsp_of(1'b0, 2'd0, 64'd0, 64'd1, TIME_MAX64, 1'b1));
        add_req(FUNC_CHECK_ALL, 2'd2, 64'd0, 1'b0, 64'd0, 1'b1,
                rsp_of(1'b0, 2'd0, 64'd0, 64'd1, TIME_MAX64, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (plan[n]) begin
            case (plan[n].kind)
                ROW_CFG: begin
                    wait_idle();
                    write_reg(plan[n].addr, plan[n].value);
                end
                ROW_REQ:    send_request(plan[n].req, plan[n].typed, plan[n].typed_rsp);
                ROW_RANDOM: run_random_phases();
                default: ;
            endcase
        end
        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("windowed_quota_counter_core test passed");
        end else begin
            $display("windowed_quota_counter_core test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("windowed_quota_counter_core test failed");
        $finish;
    end

endmodule

// ===== windowed_quota_counter_core.f =====
hdl/wqc_pkg.sv
hdl/windowed_quota_counter_core.sv
bench/windowed_quota_counter_core_tb.sv
